FILE: hdl/fbe_pkg.sv
// shared types, constants and helpers for the panel frame buffer engine
// no dependencies
package fbe_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int MEM_BYTES  = 2 * MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = $clog2(MEM_BYTES);
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);

	localparam logic [2:0] CMD_SET    = 3'd0;
	localparam logic [2:0] CMD_GET    = 3'd1;
	localparam logic [2:0] CMD_FILL   = 3'd2;
	localparam logic [2:0] CMD_INVERT = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	localparam logic [2:0] REG_LAYOUT = 3'd0;
	localparam logic [2:0] REG_WIDTH  = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_HIGH   = 3'd3;
	localparam logic [2:0] REG_LOW    = 3'd4;

	localparam logic [7:0] GREY_LIMIT = 8'd150;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [7:0]  rect_width;
		logic [7:0]  rect_height;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [63:0] fill_pattern;
		logic        pattern_is_columns;
		logic [13:0] byte_offset;
	} fbe_cmd_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] byte_out;
		logic       status;
	} fbe_res_t;

	typedef struct packed {
		logic        layout_mode;
		logic [7:0]  frame_width;
		logic [6:0]  frame_height;
		logic [23:0] high_color;
		logic [23:0] low_color;
	} fbe_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic clr_step;
	} fbe_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic ign;
		logic is_clear;
		logic last;
		logic clr_last;
	} fbe_sts_t;

	function automatic logic [15:0] pack565(input logic [23:0] c);
		pack565 = {c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

FILE: hdl/fbe_ctrl.sv
// controller state machine of the frame buffer engine
// depends on fbe_pkg
module fbe_ctrl import fbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	output logic     res_valid,
	input  logic     res_ready,
	input  fbe_sts_t sts,
	output fbe_ctl_t ctl
);

	typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_RD, ST_WR, ST_CLR, ST_OUT} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			case (state_q)
				ST_INIT: if (sts.clr_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (cmd_valid) begin
						if (sts.ign) state_q <= ST_OUT;
						else if (sts.is_clear) state_q <= ST_CLR;
						else state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_WR;
				ST_WR:  state_q <= sts.last ? ST_OUT : ST_RD;
				ST_CLR: if (sts.clr_last) state_q <= ST_OUT;
				ST_OUT: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_ready    = (state_q == ST_IDLE);
	assign res_valid    = (state_q == ST_OUT);
	assign ctl.load     = cmd_ready && cmd_valid;
	assign ctl.step     = (state_q == ST_WR);
	assign ctl.clr_step = (state_q == ST_INIT) || (state_q == ST_CLR);

endmodule

FILE: hdl/fbe_datapath.sv
// datapath: frame memory, pixel walk counters, byte update and result forming
// depends on fbe_pkg
module fbe_datapath import fbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fbe_cmd_t cmd,
	input  fbe_cfg_t cfg,
	input  fbe_ctl_t ctl,
	output fbe_sts_t sts,
	output fbe_res_t res
);

	logic [7:0] mem [MEM_BYTES];

	logic [2:0]  cmd_q;
	logic [XW-1:0] x_q, i_q;
	logic [YW-1:0] y_q, j_q;
	logic [XW:0] rw_q;
	logic [YW:0] rh_q;
	logic [15:0] word_q;
	logic        on_q;
	logic [63:0] col_q;
	logic [13:0] boff_q;
	logic        ign_q;
	logic        sel_q;
	logic [15:0] cap_q;
	logic [7:0]  rdata_q;
	logic [AW-1:0] clr_q;

	logic [15:0] eff_w, eff_h, in_x, in_y, len, pages, lim_w, lim_h;
	logic [63:0] col_in;
	logic        ign_in;

	always_comb begin
		eff_w = (16'(cfg.frame_width) < 16'(MAX_WIDTH)) ? 16'(cfg.frame_width)
			: 16'(MAX_WIDTH);
		eff_h = (16'(cfg.frame_height) < 16'(MAX_HEIGHT)) ? 16'(cfg.frame_height)
			: 16'(MAX_HEIGHT);
		pages = (eff_h + 16'd7) >> 3;
		len   = cfg.layout_mode ? 16'((eff_w * eff_h) << 1) : 16'(eff_w * pages);
		in_x  = 16'(cmd.pos_x);
		in_y  = 16'(cmd.pos_y);
		lim_w = eff_w - in_x;
		lim_h = eff_h - in_y;
		ign_in = 1'b0;
		if (eff_w == 16'd0 || eff_h == 16'd0 || cmd.command > CMD_CLEAR) begin
			ign_in = 1'b1;
		end else begin
			case (cmd.command)
				CMD_SET, CMD_GET: ign_in = (in_x >= eff_w) || (in_y >= eff_h);
				CMD_FILL, CMD_INVERT: ign_in = (in_x >= eff_w) || (in_y >= eff_h) ||
					(cmd.rect_width == 8'd0) || (cmd.rect_height == 8'd0);
				CMD_READ: ign_in = (16'(cmd.byte_offset) >= len);
				default: ign_in = 1'b0;
			endcase
		end
	end

	// column c bit r at index 8c+r
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			for (int r = 0; r < 8; r++) begin
				col_in[8*c+r] = cmd.pattern_is_columns ? cmd.fill_pattern[8*c+r]
					: cmd.fill_pattern[8*r+7-c];
			end
		end
	end

	// current pixel and byte
	logic [15:0] px, py, pix_addr;
	logic [AW-1:0] addr;
	logic        rgb_pix, last_sel, on_pix, we;
	logic [7:0]  mask, wdata, wbyte;
	logic [15:0] fw;

	always_comb begin
		sts.ign      = ign_in;
		sts.is_clear = (cmd.command == CMD_CLEAR);
		px = 16'(x_q) + 16'(i_q);
		py = 16'(y_q) + 16'(j_q);
		rgb_pix = cfg.layout_mode && (cmd_q != CMD_READ);
		pix_addr = rgb_pix ? 16'(((px + 16'(eff_w * py)) << 1) + 16'(sel_q))
			: 16'(px + 16'(eff_w * (py >> 3)));
		if (ctl.clr_step) addr = clr_q;
		else if (cmd_q == CMD_READ) addr = AW'(boff_q);
		else addr = pix_addr[AW-1:0];
		last_sel = rgb_pix ? sel_q : 1'b1;
		sts.last = last_sel && (16'(i_q) == 16'(rw_q) - 16'd1)
			&& (16'(j_q) == 16'(rh_q) - 16'd1);
		sts.clr_last = (32'(clr_q) == 32'(MEM_BYTES - 1));
		on_pix = col_q[{i_q[2:0], j_q[2:0]}];
		mask = 8'd1 << py[2:0];
		case (cmd_q)
			CMD_SET:  fw = word_q;
			CMD_FILL: fw = on_pix ? pack565(cfg.high_color) : pack565(cfg.low_color);
			default:  fw = ~{rdata_q, rdata_q};
		endcase
		wbyte = sel_q ? fw[7:0] : fw[15:8];
		if (cfg.layout_mode) begin
			wdata = wbyte;
		end else begin
			case (cmd_q)
				CMD_SET:  wdata = on_q ? (rdata_q | mask) : (rdata_q & ~mask);
				CMD_FILL: wdata = on_pix ? (rdata_q | mask) : (rdata_q & ~mask);
				default:  wdata = rdata_q ^ mask;
			endcase
		end
		we = ctl.step && (cmd_q == CMD_SET || cmd_q == CMD_FILL || cmd_q == CMD_INVERT);
	end

	always_ff @(posedge clk) begin
		if (ctl.clr_step) mem[addr] <= 8'd0;
		else if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_step) begin
			clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd.command;
			x_q    <= cmd.pos_x[XW-1:0];
			y_q    <= cmd.pos_y[YW-1:0];
			if (cmd.command == CMD_FILL || cmd.command == CMD_INVERT) begin
				rw_q <= (16'(cmd.rect_width) > lim_w) ? lim_w[XW:0] : (XW+1)'(cmd.rect_width);
				rh_q <= (16'(cmd.rect_height) > lim_h) ? lim_h[YW:0] : (YW+1)'(cmd.rect_height);
			end else begin
				rw_q <= (XW+1)'(1);
				rh_q <= (YW+1)'(1);
			end
			word_q <= pack565({cmd.red_in, cmd.green_in, cmd.blue_in});
			on_q   <= (cmd.red_in > GREY_LIMIT) && (cmd.green_in > GREY_LIMIT)
				&& (cmd.blue_in > GREY_LIMIT);
			col_q  <= col_in;
			boff_q <= cmd.byte_offset;
			ign_q  <= ign_in;
			i_q    <= '0;
			j_q    <= '0;
			sel_q  <= 1'b0;
			cap_q  <= '0;
		end else if (ctl.step) begin
			cap_q <= {cap_q[7:0], rdata_q};
			if (!last_sel) begin
				sel_q <= 1'b1;
			end else begin
				sel_q <= 1'b0;
				if (16'(i_q) == 16'(rw_q) - 16'd1) begin
					i_q <= '0;
					j_q <= j_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	logic [23:0] color;
	always_comb begin
		color = 24'd0;
		if (cmd_q == CMD_GET) begin
			if (ign_q) color = cfg.low_color;
			else if (cfg.layout_mode)
				color = {cap_q[15:11], 3'b111, cap_q[10:5], 2'b11, cap_q[4:0], 3'b111};
			else color = cap_q[{1'b0, y_q[2:0]}] ? cfg.high_color : cfg.low_color;
		end
		res.red_out   = color[23:16];
		res.green_out = color[15:8];
		res.blue_out  = color[7:0];
		res.byte_out  = (cmd_q == CMD_READ && !ign_q) ? cap_q[7:0] : 8'd0;
		res.status    = ign_q;
	end

endmodule

FILE: hdl/panel_frame_buffer_engine_core.sv
// top level of the panel frame buffer engine: register file and APB port
// depends on fbe_pkg, fbe_ctrl, fbe_datapath
// each buffer byte touched takes a read step and a write step; the result is then held
// mono pixel ops and read byte touch one byte, RGB565 pixel ops two; ignored items touch none
// rectangles touch rw*rh bytes mono, 2*rw*rh RGB565; clear zeroes all MEM_BYTES (16384)
// throughput one item at a time, set by the single read-modify-write memory port
// after reset a clearing pass zeroes the memory before the first item is taken
module panel_frame_buffer_engine_core import fbe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  fbe_cmd_t    cmd,
	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output fbe_res_t    res,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	fbe_cfg_t cfg_q;
	fbe_ctl_t ctl;
	fbe_sts_t sts;

	assign pready = 1'b1;

	// register write at the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layout_mode  <= 1'b0;
			cfg_q.frame_width  <= 8'd0;
			cfg_q.frame_height <= 7'd0;
			cfg_q.high_color   <= 24'hffffff;
			cfg_q.low_color    <= 24'd0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_LAYOUT: cfg_q.layout_mode  <= pwdata[0];
				REG_WIDTH:  cfg_q.frame_width  <= pwdata[7:0];
				REG_HEIGHT: cfg_q.frame_height <= pwdata[6:0];
				REG_HIGH:   cfg_q.high_color   <= pwdata[23:0];
				REG_LOW:    cfg_q.low_color    <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[4:2])
			REG_LAYOUT: prdata = {31'd0, cfg_q.layout_mode};
			REG_WIDTH:  prdata = {24'd0, cfg_q.frame_width};
			REG_HEIGHT: prdata = {25'd0, cfg_q.frame_height};
			REG_HIGH:   prdata = {8'd0, cfg_q.high_color};
			REG_LOW:    prdata = {8'd0, cfg_q.low_color};
			default:    prdata = 32'd0;
		endcase
	end

	// sequencer: clearing pass, byte read/write steps, result hold
	fbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// frame memory and pixel walk
	fbe_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.ctl    (ctl),
		.sts    (sts),
		.res    (res)
	);

endmodule
